/* hdl/trj_pkg.sv */
// ----------------------------------------------------------------------------
// Trajectory interpolator package
// Request/response types, status codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package trj_pkg;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Q16.16 one, used as the multiplier for the velocity term
    localparam logic [31:0] VEL_SCALE = 32'h0001_0000;

    // signed quotient width out of the muldiv unit
    localparam int QUO_W = 35;

    typedef struct packed {
        logic        action;
        logic [31:0] point_time;
        logic [31:0] point_north;
        logic [31:0] point_east;
        logic [31:0] point_down;
        logic [31:0] query_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] cmd_north;
        logic [31:0] cmd_east;
        logic [31:0] cmd_down;
        logic [31:0] vel_north;
        logic [31:0] vel_east;
        logic [31:0] vel_down;
        logic        completed;
        logic [5:0]  nearest_index;
    } rsp_t;

    // one table entry as stored in RAM
    typedef struct packed {
        logic [31:0] tm;
        logic [31:0] north;
        logic [31:0] east;
        logic [31:0] down;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    // magnitude of a 33-bit signed difference of two 32-bit values
    function automatic logic [31:0] mag33(input logic [32:0] v);
        logic [32:0] n;
        n = v[32] ? (~v + 33'd1) : v;
        return n[31:0];
    endfunction

    // saturate a 36-bit signed value to 32 bits
    function automatic logic [31:0] sat36(input logic [35:0] v);
        logic [31:0] r;
        if (v[35] && !(&v[34:31]))
            r = 32'h8000_0000;
        else if (!v[35] && (|v[34:31]))
            r = 32'h7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hdl/trj_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trj_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/trj_muldiv.sv */
// ----------------------------------------------------------------------------
// Shared multiply-divide unit
// |a|*|b|/|d| truncated, one 32x32 product then 64 restoring divide steps.
// ----------------------------------------------------------------------------
module trj_muldiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [31:0]               a_mag,
    input  logic [31:0]               b_mag,
    input  logic [31:0]               d_mag,
    input  logic                      neg,
    output logic                      done,
    output logic [trj_pkg::QUO_W-1:0] quo
);
    import trj_pkg::*;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_DONE = 4'b1000
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] a_reg, b_reg, d_reg;
    logic        neg_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [33:0] quo_reg;
    logic        sat_reg;

    logic [32:0] r2;
    logic        ge;
    logic [32:0] r_new;
    logic [33:0] mag;

    assign r2    = {rem_reg, dvd_reg[63]};
    assign ge    = r2 >= {1'b0, d_reg};
    assign r_new = ge ? (r2 - {1'b0, d_reg}) : r2;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    state_next = U_MUL;
                end
            end
            U_MUL:
            begin
                cnt_next   = 7'd64;
                state_next = U_DIV;
            end
            U_DIV:
            begin
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    state_next = U_DONE;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            d_reg   <= d_mag;
            neg_reg <= neg;
        end
        if (state_reg == U_MUL)
        begin
            dvd_reg <= a_reg * b_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            sat_reg <= 1'b0;
        end
        if (state_reg == U_DIV)
        begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            rem_reg <= r_new[31:0];
            quo_reg <= {quo_reg[32:0], ge};
            sat_reg <= sat_reg | quo_reg[33];
        end
    end

    // a saturated quotient only needs to be large enough to clip downstream
    assign mag  = sat_reg ? 34'h2_0000_0000 : quo_reg;
    assign quo  = neg_reg ? (~{1'b0, mag} + 35'd1) : {1'b0, mag};
    assign done = (state_reg == U_DONE);

endmodule

/* hdl/trajectory_point_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// Trajectory point interpolator
// Sequence: a load stores the point unless the table is full; a query scans
//   the N stored points at one RAM read per point, picks and fetches the
//   segment, then runs six muldiv passes in the shared unit, two per axis.
//   Held point or zero-length segment: no muldiv. Empty-table query: no scan.
// Throughput: one request at a time; set by the scan, the shared divider and rsp_stall.
// Reset: point count clears, table contents stay undefined until written.
// ----------------------------------------------------------------------------
module trajectory_point_interpolator_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  trj_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output trj_pkg::rsp_t rsp
);
    import trj_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // sequencer: scan table, pick segment, fetch both ends, run muldivs
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_SEL     = 9'b000000100,
        S_RDA     = 9'b000001000,
        S_RDB     = 9'b000010000,
        S_LATB    = 9'b000100000,
        S_MD_GO   = 9'b001000000,
        S_MD_WAIT = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    // control
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            pend_reg, pend_next;
    logic [1:0]      axis_reg, axis_next;
    logic            op_reg, op_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            query_reg, query_next;

    // payload
    logic [31:0]     q_reg, q_next;
    logic [1:0]      status_reg, status_next;
    logic [AW-1:0]   pend_idx_reg, pend_idx_next;
    logic [31:0]     best_reg, best_next;
    logic [31:0]     best_t_reg, best_t_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            done_reg, done_next;
    logic [AW-1:0]   a_reg, a_next;
    logic [AW-1:0]   b_reg, b_next;
    logic [31:0]     t0_reg, t0_next;
    logic [31:0]     t1_reg, t1_next;
    logic [31:0]     pa_reg [3];
    logic [31:0]     pa_next [3];
    logic [31:0]     pb_reg [3];
    logic [31:0]     pb_next [3];
    logic [31:0]     cmd_reg [3];
    logic [31:0]     cmd_next [3];
    logic [31:0]     vel_reg [3];
    logic [31:0]     vel_next [3];
    rsp_t            rsp_reg, rsp_next;

    // RAM
    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    point_t          wr_pt;
    logic [POINT_W-1:0] rd_data;
    point_t          rd_pt;

    // shared unit
    logic            md_start;
    logic [31:0]     md_a, md_b, md_d;
    logic            md_neg;
    logic            md_done;
    logic [QUO_W-1:0] md_quo;

    // per-axis operands
    logic [31:0]     pa_k, pb_k;
    logic [32:0]     dp, dq, dt;
    logic [35:0]     pos_sum;
    logic [31:0]     tm_gap;

    assign wr_pt.tm    = req.point_time;
    assign wr_pt.north = req.point_north;
    assign wr_pt.east  = req.point_east;
    assign wr_pt.down  = req.point_down;
    assign rd_pt       = rd_data;

    trj_ram #(
        .WIDTH(POINT_W),
        .DEPTH(MAX_POINTS)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(wr_pt),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    trj_muldiv u_muldiv (
        .clk  (clk),
        .rst_n(rst_n),
        .start(md_start),
        .a_mag(md_a),
        .b_mag(md_b),
        .d_mag(md_d),
        .neg  (md_neg),
        .done (md_done),
        .quo  (md_quo)
    );

    // segment deltas, all fit in 33 bits signed
    assign pa_k    = pa_reg[axis_reg];
    assign pb_k    = pb_reg[axis_reg];
    assign dp      = {pb_k[31], pb_k} - {pa_k[31], pa_k};
    assign dq      = {1'b0, q_reg} - {1'b0, t0_reg};
    assign dt      = {1'b0, t1_reg} - {1'b0, t0_reg};
    assign md_a    = mag33(dp);
    assign md_b    = op_reg ? VEL_SCALE : mag33(dq);
    assign md_d    = mag33(dt);
    assign md_neg  = dp[32] ^ (op_reg ? 1'b0 : dq[32]) ^ dt[32];
    assign pos_sum = {{4{pa_k[31]}}, pa_k} + {md_quo[QUO_W-1], md_quo};

    // distance of the scanned entry from the query time
    assign tm_gap = (rd_pt.tm >= q_reg) ? (rd_pt.tm - q_reg) : (q_reg - rd_pt.tm);

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        axis_next      = axis_reg;
        op_next        = op_reg;
        rsp_valid_next = rsp_valid_reg;
        query_next     = query_reg;
        q_next         = q_reg;
        status_next    = status_reg;
        pend_idx_next  = pend_idx_reg;
        best_next      = best_reg;
        best_t_next    = best_t_reg;
        idx_next       = idx_reg;
        done_next      = done_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        cmd_next       = cmd_reg;
        vel_next       = vel_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        rd_addr        = '0;
        md_start       = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    query_next = (req.action == ACT_QUERY);
                    q_next     = req.query_time;
                    state_next = S_DONE;
                    if (req.action == ACT_LOAD)
                    begin
                        if (count_reg < CW'(MAX_POINTS))
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CW'(1);
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        issue_next  = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle, compare the one that came back
                rd_addr       = issue_reg[AW-1:0];
                pend_idx_next = issue_reg[AW-1:0];
                if (issue_reg < count_reg)
                begin
                    pend_next  = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (pend_idx_reg == '0 || tm_gap < best_reg)
                    begin
                        best_next   = tm_gap;
                        best_t_next = rd_pt.tm;
                        idx_next    = pend_idx_reg;
                    end
                    if (CW'(pend_idx_reg) == count_reg - CW'(1))
                    begin
                        done_next  = (q_reg > rd_pt.tm);
                        state_next = S_SEL;
                    end
                end
            end
            S_SEL:
            begin
                if (idx_reg == '0)
                begin
                    a_next = '0;
                    b_next = '0;
                end
                else if (q_reg < best_t_reg)
                begin
                    a_next = idx_reg - AW'(1);
                    b_next = idx_reg;
                end
                else if (CW'(idx_reg) + CW'(1) >= count_reg)
                begin
                    a_next = idx_reg;
                    b_next = idx_reg;
                end
                else
                begin
                    a_next = idx_reg;
                    b_next = idx_reg + AW'(1);
                end
                state_next = S_RDA;
            end
            S_RDA:
            begin
                rd_addr    = a_reg;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                rd_addr    = b_reg;
                t0_next    = rd_pt.tm;
                pa_next[0] = rd_pt.north;
                pa_next[1] = rd_pt.east;
                pa_next[2] = rd_pt.down;
                state_next = S_LATB;
            end
            S_LATB:
            begin
                t1_next    = rd_pt.tm;
                pb_next[0] = rd_pt.north;
                pb_next[1] = rd_pt.east;
                pb_next[2] = rd_pt.down;
                axis_next  = '0;
                op_next    = 1'b0;
                state_next = S_MD_GO;
            end
            S_MD_GO:
            begin
                // held point or zero-length segment: no division
                if (a_reg == b_reg || t0_reg == t1_reg)
                begin
                    cmd_next   = pa_reg;
                    vel_next   = '{3{32'd0}};
                    state_next = S_DONE;
                end
                else
                begin
                    md_start   = 1'b1;
                    state_next = S_MD_WAIT;
                end
            end
            S_MD_WAIT:
            begin
                if (md_done)
                begin
                    state_next = S_MD_GO;
                    if (!op_reg)
                    begin
                        cmd_next[axis_reg] = sat36(pos_sum);
                        op_next            = 1'b1;
                    end
                    else
                    begin
                        vel_next[axis_reg] = sat36({md_quo[QUO_W-1], md_quo});
                        op_next            = 1'b0;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next        = '0;
                    rsp_next.status = status_reg;
                    if (query_reg && status_reg == ST_OK)
                    begin
                        rsp_next.cmd_north     = cmd_reg[0];
                        rsp_next.cmd_east      = cmd_reg[1];
                        rsp_next.cmd_down      = cmd_reg[2];
                        rsp_next.vel_north     = vel_reg[0];
                        rsp_next.vel_east      = vel_reg[1];
                        rsp_next.vel_down      = vel_reg[2];
                        rsp_next.completed     = done_reg;
                        rsp_next.nearest_index = 6'(idx_reg);
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            axis_reg      <= '0;
            op_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            query_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            axis_reg      <= axis_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
            query_reg     <= query_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        status_reg   <= status_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        best_t_reg   <= best_t_next;
        idx_reg      <= idx_next;
        done_reg     <= done_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        cmd_reg      <= cmd_next;
        vel_reg      <= vel_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* dv/tb_trajectory_point_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// Trajectory point interpolator testbench
// Drives load and query requests through the valid/stall request channel,
// predicts each response with a behavioral model of the point table and the
// segment interpolation, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_trajectory_point_interpolator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import trj_pkg::*;

    localparam int TBL_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    // predictor copy of the point table
    logic [31:0] tbl_time [TBL_DEPTH];
    logic [31:0] tbl_north[TBL_DEPTH];
    logic [31:0] tbl_east [TBL_DEPTH];
    logic [31:0] tbl_down [TBL_DEPTH];
    int          tbl_count;

    rsp_t pending_rsp[$];
    int   err_count;
    int   idle_cycles;
    bit   rsp_hold;      // long receiver hold-off request
    bit   timed_out;

    trajectory_point_interpolator_unit #(.MAX_POINTS(TBL_DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // a*b/d truncated toward zero, magnitude clamped at 2^62
    function automatic logic signed [63:0] scaled_ratio(
        input logic signed [63:0] a, input logic signed [63:0] b,
        input logic signed [63:0] d);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  ua, ub, ud;
        logic         neg;
        if (a == 0 || b == 0 || d == 0)
            return 64'sd0;
        neg  = (a < 0) ^ (b < 0) ^ (d < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        ud   = (d < 0) ? -d : d;
        prod = {64'd0, ua} * {64'd0, ub};
        quo  = prod / {64'd0, ud};
        if (quo > (128'd1 << 62))
            quo = 128'd1 << 62;
        return neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic rsp_t predict_command(input req_t r);
        rsp_t        e;
        int          idx, a, b;
        logic [32:0] best, gap_abs;
        logic signed [63:0] q, t0, dt, pa, pb, dp, pos, vel;
        e = '0;
        if (r.action == ACT_LOAD)
        begin
            if (tbl_count >= TBL_DEPTH)
                e.status = ST_FULL;
            else
            begin
                tbl_time[tbl_count]  = r.point_time;
                tbl_north[tbl_count] = r.point_north;
                tbl_east[tbl_count]  = r.point_east;
                tbl_down[tbl_count]  = r.point_down;
                tbl_count++;
            end
            return e;
        end
        if (tbl_count == 0)
        begin
            e.status = ST_EMPTY;
            return e;
        end
        idx  = 0;
        best = '0;
        for (int i = 0; i < tbl_count; i++)
        begin
            gap_abs = (tbl_time[i] >= r.query_time) ? tbl_time[i] - r.query_time
                                                    : r.query_time - tbl_time[i];
            if (i == 0 || gap_abs < best)
            begin
                best = gap_abs;
                idx  = i;
            end
        end
        if (idx == 0)
        begin
            a = 0; b = 0;
        end
        else if (r.query_time < tbl_time[idx])
        begin
            a = idx - 1; b = idx;
        end
        else if (idx + 1 >= tbl_count)
        begin
            a = idx; b = idx;
        end
        else
        begin
            a = idx; b = idx + 1;
        end
        q  = {32'd0, r.query_time};
        t0 = {32'd0, tbl_time[a]};
        dt = {32'd0, tbl_time[b]} - t0;
        for (int k = 0; k < 3; k++)
        begin
            case (k)
                0:
                begin
                    pa = sx(tbl_north[a]); pb = sx(tbl_north[b]);
                end
                1:
                begin
                    pa = sx(tbl_east[a]);  pb = sx(tbl_east[b]);
                end
                default:
                begin
                    pa = sx(tbl_down[a]); pb = sx(tbl_down[b]);
                end
            endcase
            pos = pa;
            vel = 64'sd0;
            if (a != b && dt != 0)
            begin
                dp  = pb - pa;
                pos = pa + scaled_ratio(dp, q - t0, dt);
                vel = scaled_ratio(dp, 64'sd65536, dt);
            end
            case (k)
                0:
                begin
                    e.cmd_north = clamp32(pos); e.vel_north = clamp32(vel);
                end
                1:
                begin
                    e.cmd_east  = clamp32(pos); e.vel_east  = clamp32(vel);
                end
                default:
                begin
                    e.cmd_down = clamp32(pos); e.vel_down = clamp32(vel);
                end
            endcase
        end
        e.completed     = r.query_time > tbl_time[tbl_count - 1];
        e.nearest_index = idx[5:0];
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // valid stays up into the next request when no idle gap is drawn
    task automatic send_request(input req_t r);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        pending_rsp.insert(pending_rsp.size(), predict_command(r));
    endtask

    task automatic send_load(input logic [31:0] t, input logic [31:0] n,
                             input logic [31:0] e, input logic [31:0] d);
        req_t r;
        r = '0;
        r.action      = ACT_LOAD;
        r.point_time  = t;
        r.point_north = n;
        r.point_east  = e;
        r.point_down  = d;
        r.query_time  = $urandom;
        send_request(r);
    endtask

    task automatic send_query(input logic [31:0] t);
        req_t         r;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(req_t)-1:0];
        r.action     = ACT_QUERY;
        r.query_time = t;
        send_request(r);
    endtask

    task automatic drain_responses;
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // random query time, biased toward stored times and their neighbors
    function automatic logic [31:0] pick_query_time;
        logic [31:0] t;
        if (tbl_count == 0 || $urandom_range(0, 4) == 0)
            return $urandom;
        t = tbl_time[$urandom_range(0, tbl_count - 1)];
        case ($urandom_range(0, 3))
            0: return t;
            1: return t + $urandom_range(0, 65536);
            2: return t - $urandom_range(0, 65536);
            default: return t + $urandom_range(0, 8);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // empty-table query, single point hold, flat plus duplicate times, extremes
    task automatic test_directed;
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);
        send_load(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_query(32'h0);
        send_query(32'h0001_0000);
        send_query(32'hFFFF_FFFF);
        send_load(32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000);
        send_load(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
        send_load(32'h0003_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_load(32'h0000_0000, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_8000);
        send_load(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'h0002_0000);
        send_query(32'h0003_0000);
        send_query(32'h0003_0001);
        send_query(32'h0002_8000);
        send_query(32'h0001_8000);
        send_query(32'h8000_0000);
        send_query(32'hFFFF_FFFE);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0001);
        drain_responses();
    endtask

    // fill the table to the last slot, then overflow it
    task automatic test_fill_and_full;
        logic [31:0] t;
        t = tbl_time[tbl_count - 1];
        while (tbl_count < TBL_DEPTH)
        begin
            t = ($urandom_range(0, 7) == 0) ? $urandom : t + $urandom_range(0, 20'hF_FFFF);
            send_load(t, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 2) == 0)
                send_query(pick_query_time());
        end
        for (int i = 0; i < 6; i++)
            send_load($urandom, $urandom, $urandom, $urandom);
        send_query(tbl_time[TBL_DEPTH - 1]);
        send_query(tbl_time[TBL_DEPTH - 1] + 32'd1);
        drain_responses();
    endtask

    // long receiver hold-off while the sender keeps offering requests
    task automatic test_backpressure;
        rsp_hold = 1'b1;
        for (int i = 0; i < 12; i++)
            send_query(pick_query_time());
        drain_responses();
    endtask

    // random query traffic against the full table; loads only bounce
    task automatic test_random_traffic(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_load($urandom, $urandom, $urandom, $urandom);
            else
                send_query(pick_query_time());
        end
        drain_responses();
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // per-response random stall, or a long stretch when a hold-off is asked
    initial
    begin
        int hold;
        rsp_stall <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rsp_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                rsp_hold = 1'b0;
            end
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (hold == 0)
                rsp_stall <= 1'b0;
            else
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
            rsp_stall <= 1'b1;
        end
    end

    // compare every accepted response with the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected response", 32'(rsp.status), 32'd0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.cmd_north !== want.cmd_north)
                    report_mismatch("cmd_north", rsp.cmd_north, want.cmd_north);
                if (rsp.cmd_east !== want.cmd_east)
                    report_mismatch("cmd_east", rsp.cmd_east, want.cmd_east);
                if (rsp.cmd_down !== want.cmd_down)
                    report_mismatch("cmd_down", rsp.cmd_down, want.cmd_down);
                if (rsp.vel_north !== want.vel_north)
                    report_mismatch("vel_north", rsp.vel_north, want.vel_north);
                if (rsp.vel_east !== want.vel_east)
                    report_mismatch("vel_east", rsp.vel_east, want.vel_east);
                if (rsp.vel_down !== want.vel_down)
                    report_mismatch("vel_down", rsp.vel_down, want.vel_down);
                if (rsp.completed !== want.completed)
                    report_mismatch("completed", rsp.completed, want.completed);
                if (rsp.nearest_index !== want.nearest_index)
                    report_mismatch("nearest_index", rsp.nearest_index,
                                    want.nearest_index);
            end
        end
    end

    // watchdog: cycles with no request or response accepted
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_hold    = 1'b0;
        idle_cycles = 0;
        err_count   = 0;
        tbl_count   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_full();
        test_backpressure();
        test_random_traffic(640);

        repeat (600) @(posedge clk);
        if (err_count == 0 && pending_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/trj_pkg.sv
hdl/trj_ram.sv
hdl/trj_muldiv.sv
hdl/trajectory_point_interpolator_unit.sv
dv/tb_trajectory_point_interpolator_unit.sv
